[rtl/core/audio_routing_mixer_unit_macros.svh]
`ifndef AUDIO_ROUTING_MIXER_UNIT_MACROS_SVH
`define AUDIO_ROUTING_MIXER_UNIT_MACROS_SVH

// Concurrent checks clocked on clk and held off while rst_n is low.
// The enclosing module must have signals named clk and rst_n.

// Same-cycle implication.
`define ARM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed: same-cycle implication");

// Next-cycle implication.
`define ARM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer check failed: next-cycle implication");

`endif

[rtl/core/arm_pkg.sv]
package arm_pkg;

    // Fixed field widths of the ports.
    localparam int SRC_W      = 2;
    localparam int SCH_W      = 3;
    localparam int SAMPLE_W   = 16;
    localparam int OCH_W      = 3;
    localparam int ACTIVE_W   = 4;
    localparam int SET_W      = 24;
    localparam int MASK_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int FRAC_BITS  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int SRC_SLOTS  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE = 3'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = 4'd2;
    localparam logic [SET_W-1:0]    SETTING_RESET = 24'h400000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_READ,
        ST_LOAD
    } arm_state_t;

    typedef struct packed {
        logic             hit;
        logic [OCH_W-1:0] ch;
    } arm_route_t;

    // Output channel of the n-th set bit of the mask.
    function automatic arm_route_t arm_route(input logic [MASK_W-1:0] mask,
                                             input logic [SCH_W-1:0] n);
        arm_route_t r;
        logic [3:0] seen;
        r    = '0;
        seen = '0;
        for (int b = 0; b < MASK_W; b++)
        begin
            if (mask[b])
            begin
                if (seen == 4'(n) && !r.hit)
                begin
                    r.hit = 1'b1;
                    r.ch  = OCH_W'(b);
                end
                seen = seen + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/arm_ram.sv]
module arm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/audio_routing_mixer_unit.sv]
// Channel   Direction  Handshake              Carries
// in        input      in_valid / in_ready    source, source_channel, sample, frame_end
// out       output     out_valid / out_ready  out_channel, mixed_sample, last_of_frame
// cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// In the transfer cycle of a sample the channel accumulator is read from the RAM and
// the gained product formed; the next cycle adds and writes the sum back.
// A frame end then passes through a RAM read and an output load for each active
// channel, each load waiting while the output register is stalled by out_ready.
// Reset clears control state only; accumulators read as zero through per-entry valid
// bits, all cleared when a frame's last channel is loaded or it ends with none active.
// A finished result waits in the output register while the next sample is taken.

`include "audio_routing_mixer_unit_macros.svh"

module audio_routing_mixer_unit #(
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int SOURCE_COUNT     = 4,
    parameter int SAMPLE_WIDTH     = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [arm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arm_pkg::SET_W-1:0]       cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [arm_pkg::SRC_W-1:0]       source,
    input  logic [arm_pkg::SCH_W-1:0]       source_channel,
    input  logic signed [arm_pkg::SAMPLE_W-1:0] sample,
    input  logic                            frame_end,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [arm_pkg::OCH_W-1:0]       out_channel,
    output logic signed [arm_pkg::SAMPLE_W-1:0] mixed_sample,
    output logic                            last_of_frame
);

    import arm_pkg::*;

    localparam int AW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int EXT_W = ACC_W + 1;
    localparam int Q_W = EXT_W - FRAC_BITS;
    localparam logic [5:0] MAX_CH = 6'(MAX_OUT_CHANNELS);
    localparam logic [4:0] SRC_LIMIT = 5'(SOURCE_COUNT);
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - Q_W'(1);
    localparam logic signed [EXT_W-1:0] ROUND_HALF = EXT_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [EXT_W-1:0] ACC_MAX = EXT_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] ACC_MIN = -ACC_MAX - EXT_W'(1);

    // Configuration registers. Only sources below SOURCE_COUNT are ever written.
    logic [ACTIVE_W-1:0] active_reg;
    logic [SET_W-1:0]    setting_reg [SRC_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            for (int i = 0; i < SRC_SLOTS; i++)
            begin
                setting_reg[i] <= SETTING_RESET;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ACTIVE)
            begin
                active_reg <= cfg_data[ACTIVE_W-1:0];
            end
            for (int i = 0; i < SRC_SLOTS; i++)
            begin
                if (i < SOURCE_COUNT && cfg_index == REG_SRC_BASE + CFG_IDX_W'(i))
                begin
                    setting_reg[i] <= cfg_data;
                end
            end
        end
    end

    // The active count is clamped to the accumulator depth.
    logic [5:0] act_eff;
    assign act_eff = ({2'b00, active_reg} > MAX_CH) ? MAX_CH : {2'b00, active_reg};

    // Input decode: route the compacted channel through the source mask and form the
    // gained product in Q.14.
    logic [SET_W-1:0]          sel_setting;
    logic signed [GAIN_W-1:0]  gain;
    arm_route_t                route;
    logic                      in_hit;
    logic signed [PROD_W-1:0]  in_prod;

    always_comb
    begin
        sel_setting = setting_reg[source];
        gain        = sel_setting[SET_W-1:MASK_W];
        route       = arm_route(sel_setting[MASK_W-1:0], source_channel);
        in_hit      = ({3'b000, source} < SRC_LIMIT) && route.hit
                      && ({3'b000, route.ch} < act_eff);
        in_prod     = sample * gain;
    end

    // Control state.
    arm_state_t          state_reg, state_next;
    logic [3:0]          idx_reg, idx_next;
    logic                hit_reg;
    logic                fend_reg;
    logic [AW-1:0]       ch_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAX_OUT_CHANNELS-1:0] valid_reg;
    logic                rd_valid_reg;

    logic                out_valid_reg;
    logic [OCH_W-1:0]    out_channel_reg;
    logic signed [SAMPLE_W-1:0] mixed_reg;
    logic                last_reg;

    // Handshake and RAM control.
    logic          in_fire;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic          out_load;
    logic          emit_last;
    logic          clear_all;

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        in_fire   = in_valid && in_ready;
        mem_re    = in_fire || (state_reg == ST_READ);
        mem_raddr = (state_reg == ST_READ) ? AW'(idx_reg) : AW'(route.ch);
        mem_we    = (state_reg == ST_ACC) && hit_reg;
        out_load  = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);
        emit_last = ({2'b00, idx_reg} + 6'd1) == act_eff;
        clear_all = ((state_reg == ST_ACC) && fend_reg && (act_eff == 6'd0))
                    || (out_load && emit_last);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (fend_reg && act_eff != 6'd0)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_load)
                begin
                    state_next = emit_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (state_reg == ST_ACC)
        begin
            idx_next = '0;
        end
        else if (out_load && !emit_last)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            fend_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (in_fire)
            begin
                hit_reg  <= in_hit;
                fend_reg <= frame_end;
            end
            if (mem_re)
            begin
                rd_valid_reg <= valid_reg[mem_raddr];
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (mem_we)
            begin
                valid_reg[ch_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg   <= AW'(route.ch);
            prod_reg <= in_prod;
        end
    end

    // Accumulator RAM. An entry whose valid bit is clear reads as zero.
    logic [ACC_W-1:0]         mem_rdata;
    logic [ACC_W-1:0]         mem_wdata;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [EXT_W-1:0]  acc_sum;
    logic signed [EXT_W-1:0]  acc_rnd;
    logic signed [Q_W-1:0]    q_val;
    logic signed [SAMPLE_WIDTH-1:0] q_sat;

    arm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUT_CHANNELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ch_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        acc_rd  = rd_valid_reg ? $signed(mem_rdata) : '0;

        // Saturating add of the product into the 40-bit sum.
        acc_sum = EXT_W'(acc_rd) + EXT_W'(prod_reg);
        if (acc_sum > ACC_MAX)
        begin
            mem_wdata = ACC_MAX[ACC_W-1:0];
        end
        else if (acc_sum < ACC_MIN)
        begin
            mem_wdata = ACC_MIN[ACC_W-1:0];
        end
        else
        begin
            mem_wdata = acc_sum[ACC_W-1:0];
        end

        // Round half up, drop the fraction, saturate to the sample range.
        acc_rnd = EXT_W'(acc_rd) + ROUND_HALF;
        q_val   = acc_rnd[EXT_W-1:FRAC_BITS];
        if (q_val > Q_HI)
        begin
            q_sat = Q_HI[SAMPLE_WIDTH-1:0];
        end
        else if (q_val < Q_LO)
        begin
            q_sat = Q_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            q_sat = q_val[SAMPLE_WIDTH-1:0];
        end
    end

    // Output register: holds a result until its transfer while the input side goes on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_channel_reg <= idx_reg[OCH_W-1:0];
            mixed_reg       <= SAMPLE_W'(q_sat);
            last_reg        <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign mixed_sample  = mixed_reg;
    assign last_of_frame = last_reg;

    // The emission counter never runs past the active channel count.
    `ARM_ASSERT_IMP(a_idx_in_range, (state_reg == ST_READ || state_reg == ST_LOAD),
                    ({2'b00, idx_reg} < act_eff))
    // After the last channel of a frame is loaded, every accumulator reads as zero.
    `ARM_ASSERT_NXT(a_clear_after_frame, (out_load && emit_last), (valid_reg == '0))
    // The final result of a frame carries the highest active channel.
    `ARM_ASSERT_IMP(a_last_channel, (out_valid && last_of_frame),
                    ({3'b000, out_channel} == act_eff - 6'd1))
    // A write-back only targets a channel inside the active range.
    `ARM_ASSERT_IMP(a_write_active, mem_we, ({{(6-AW){1'b0}}, ch_reg} < act_eff))

endmodule

[sim/testbench.sv]
module testbench;
    import arm_pkg::*;

    // Time allowed for the block to finish work that no result reveals, such
    // as a sample still being added into its accumulator.
    localparam int SETTLE_CYCLES = 24;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 2000;
    // Index past the last source register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

    // Mirrors the mixer: register copies, the per-channel sums, and the queue
    // of mixed channels that the block still owes.
    class mix_tracker;
        typedef struct packed {
            logic [OCH_W-1:0]           channel;
            logic signed [SAMPLE_W-1:0] value;
            logic                       last;
        } mix_t;

        localparam int     OUT_CHANNELS = 8;
        localparam longint ACC_TOP      = 40'sh7F_FFFF_FFFF;
        localparam longint ACC_BOT      = -ACC_TOP - 1;

        logic [ACTIVE_W-1:0] active;
        logic [SET_W-1:0]    setting [SRC_SLOTS];
        longint              acc [OUT_CHANNELS];
        mix_t                expected_mix [$];
        int                  errors;
        int                  samples;
        int                  frames;
        int                  mixes;
        int                  settings_used;

        function new();
            active = ACTIVE_RESET;
            foreach (setting[i]) setting[i] = SETTING_RESET;
            foreach (acc[i]) acc[i] = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SET_W-1:0] data);
            if (idx == REG_ACTIVE)
                active = data[ACTIVE_W-1:0];
            else if (idx >= REG_SRC_BASE && idx < REG_SRC_BASE + SRC_SLOTS)
                setting[SRC_W'(idx - REG_SRC_BASE)] = data;
        endfunction

        // Output channel that carries the n-th set bit of the mask, or -1.
        function int nth_set_bit(input logic [MASK_W-1:0] mask, input logic [SCH_W-1:0] n);
            int seen;
            seen = 0;
            for (int b = 0; b < MASK_W; b++)
            begin
                if (mask[b])
                begin
                    if (seen == n)
                        return b;
                    seen++;
                end
            end
            return -1;
        endfunction

        // Round half up with a floor shift, then clamp to the sample range.
        function logic signed [SAMPLE_W-1:0] round_to_sample(input longint sum);
            longint q;
            q = (sum + 8192) >>> FRAC_BITS;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            return SAMPLE_W'(q);
        endfunction

        function void take_sample(input logic [SRC_W-1:0] src, input logic [SCH_W-1:0] sch,
                                  input logic signed [SAMPLE_W-1:0] smp, input logic fend);
            int     width;
            int     target;
            longint sum;
            mix_t   m;
            width  = (active > OUT_CHANNELS) ? OUT_CHANNELS : active;
            target = nth_set_bit(setting[src][MASK_W-1:0], sch);
            samples++;
            if (target >= 0 && target < width)
            begin
                sum = acc[target] + longint'(smp) * longint'($signed(setting[src][SET_W-1:MASK_W]));
                if (sum > ACC_TOP)
                    sum = ACC_TOP;
                else if (sum < ACC_BOT)
                    sum = ACC_BOT;
                acc[target] = sum;
            end
            if (fend)
            begin
                frames++;
                for (int i = 0; i < width; i++)
                begin
                    m.channel = OCH_W'(i);
                    m.value   = round_to_sample(acc[i]);
                    m.last    = (i == width - 1);
                    expected_mix.push_back(m);
                end
                foreach (acc[i]) acc[i] = 0;
            end
        endfunction

        task check_mix(input logic [OCH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] value,
                       input logic last);
            mix_t want;
            mixes++;
            if (expected_mix.size() == 0)
            begin
                report($sformatf("channel %0d value %0d arrived with no frame owed", ch, value));
            end
            else
            begin
                want = expected_mix.pop_front();
                if (ch !== want.channel)
                    report($sformatf("out_channel %0d, wanted %0d", ch, want.channel));
                if (value !== want.value)
                    report($sformatf("channel %0d mixed_sample %0d, wanted %0d",
                                     want.channel, value, want.value));
                if (last !== want.last)
                    report($sformatf("channel %0d last_of_frame %0b, wanted %0b",
                                     want.channel, last, want.last));
            end
        endtask
    endclass

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [SET_W-1:0]           cfg_data       = '0;
    logic                       in_valid       = 1'b0;
    logic                       in_ready;
    logic [SRC_W-1:0]           source         = '0;
    logic [SCH_W-1:0]           source_channel = '0;
    logic signed [SAMPLE_W-1:0] sample         = '0;
    logic                       frame_end      = 1'b0;
    logic                       out_valid;
    logic                       out_ready      = 1'b0;
    logic [OCH_W-1:0]           out_channel;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       last_of_frame;

    // When steady is set, neither side inserts idle cycles.
    bit         steady = 1'b0;
    int         quiet_cycles = 0;
    mix_tracker sb = new();

    audio_routing_mixer_unit dut (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The receiving side holds off in about a quarter of the cycles.
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    // Every input transfer feeds the predictor; every output transfer is
    // compared against the oldest owed channel. Values are read in the
    // active region of the edge, so they are the ones the block latched.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.take_sample(source, source_channel, sample, frame_end);
        if (rst_n && out_valid && out_ready)
            sb.check_mix(out_channel, mixed_sample, last_of_frame);
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one sample and returns at the edge where its transfer happens.
    // Valid stays high afterwards so back-to-back samples need no gap.
    task send_sample(input logic [SRC_W-1:0] src, input logic [SCH_W-1:0] sch,
                     input logic signed [SAMPLE_W-1:0] smp, input logic fend);
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        source         <= src;
        source_channel <= sch;
        sample         <= smp;
        frame_end      <= fend;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Mostly well-formed samples: the source channel usually falls inside the
    // source's mask, and the extremes of the sample range show up often.
    task send_random();
        logic [SRC_W-1:0]           src;
        logic [SCH_W-1:0]           sch;
        logic signed [SAMPLE_W-1:0] smp;
        int                         span;
        src  = SRC_W'($urandom);
        span = $countones(sb.setting[src][MASK_W-1:0]);
        if (span > 0 && $urandom_range(0, 99) < 80)
            sch = SCH_W'($urandom_range(0, span - 1));
        else
            sch = SCH_W'($urandom);
        case ($urandom_range(0, 9))
            0:       smp = SMP_MAX;
            1:       smp = SMP_MIN;
            default: smp = SAMPLE_W'($urandom);
        endcase
        send_sample(src, sch, smp, $urandom_range(0, 99) < 12);
    endtask

    // Stops offering samples until every owed channel has been transferred.
    task drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_mix.size() != 0);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SET_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Rewrites every register once the block has gone quiet. The extra wait
    // covers a trailing sample that produces no result but may still be in
    // the middle of its accumulator update.
    task configure(input logic [SET_W-1:0] act_word, input logic [SET_W-1:0] s0,
                   input logic [SET_W-1:0] s1, input logic [SET_W-1:0] s2,
                   input logic [SET_W-1:0] s3, input bit touch_spare);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_ACTIVE, act_word);
        write_reg(REG_SRC_BASE, s0);
        write_reg(REG_SRC_BASE + 3'd1, s1);
        write_reg(REG_SRC_BASE + 3'd2, s2);
        write_reg(REG_SRC_BASE + 3'd3, s3);
        if (touch_spare)
            write_reg(REG_SPARE, SET_W'($urandom));
        cfg_we <= 1'b0;
        sb.settings_used++;
    endtask

    // Random gain and mask; one mask in five routes all eight channels.
    function logic [SET_W-1:0] random_setting();
        logic [MASK_W-1:0] mask;
        mask = ($urandom_range(0, 4) == 0) ? 8'hFF : MASK_W'($urandom);
        return {GAIN_W'($urandom), mask};
    endfunction

    initial
    begin
        int unsigned phase_active [6];
        phase_active = '{1, 8, 4, 12, 6, 3};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset every mask is empty, so samples are dropped and a frame
        // end still emits the two default channels as zero.
        send_sample(2'd0, 3'd0, 16'sd1234, 1'b0);
        send_sample(2'd3, 3'd7, -16'sd1, 1'b1);

        // All eight channels, gains at +1.0, just under +2.0, -2.0 and -1.0.
        // Two channels overflow the top of the sample range, and a source channel
        // beyond its mask is dropped, also on the sample that carries the frame end.
        configure(24'h000008, {16'h4000, 8'hFF}, {16'h7FFF, 8'hAA},
                  {16'h8000, 8'h81}, {16'hC000, 8'h10}, 1'b0);
        send_sample(2'd0, 3'd0, SMP_MAX, 1'b0);
        send_sample(2'd0, 3'd7, SMP_MIN, 1'b0);
        send_sample(2'd1, 3'd3, SMP_MAX, 1'b0);
        send_sample(2'd1, 3'd4, 16'sd100, 1'b0);
        send_sample(2'd2, 3'd0, SMP_MAX, 1'b0);
        send_sample(2'd2, 3'd1, SMP_MIN, 1'b0);
        send_sample(2'd3, 3'd0, SMP_MIN, 1'b0);
        send_sample(2'd3, 3'd7, 16'sd5, 1'b1);

        // Smallest gain exercises rounding: exactly one half rounds up, just
        // below one half goes to zero, and just below minus one half goes to
        // minus one. Routes to channels past the active count are dropped.
        configure(24'h000003, {16'h0001, 8'h07}, {16'hFFFF, 8'h08},
                  {16'h4000, 8'h00}, {16'h4000, 8'hF0}, 1'b0);
        send_sample(2'd0, 3'd0, 16'sd8192, 1'b0);
        send_sample(2'd0, 3'd1, -16'sd8193, 1'b0);
        send_sample(2'd0, 3'd2, 16'sd8191, 1'b0);
        send_sample(2'd1, 3'd0, 16'sd1000, 1'b0);
        send_sample(2'd3, 3'd1, 16'sd77, 1'b1);
        // Leaves channel 0 holding a value across the next phase.
        send_sample(2'd0, 3'd0, 16'sd16384, 1'b0);

        // No active channels: nothing is mixed and a frame end emits nothing,
        // but it must still clear the value left in channel 0.
        configure(24'hABCDE0, {16'h0001, 8'h07}, {16'hFFFF, 8'h08},
                  {16'h4000, 8'h00}, {16'h4000, 8'hF0}, 1'b0);
        send_sample(2'd0, 3'd0, SMP_MIN, 1'b0);
        send_sample(2'd0, 3'd1, SMP_MAX, 1'b1);

        // An active count above eight is treated as eight. The spare register
        // index is written too and must have no effect.
        configure(24'h5A5A5F, {16'h2000, 8'h80}, {16'h4000, 8'h02},
                  {16'h4000, 8'h00}, {16'h4000, 8'h00}, 1'b1);
        send_sample(2'd0, 3'd0, SMP_MIN, 1'b0);
        send_sample(2'd1, 3'd0, SMP_MAX, 1'b0);
        send_sample(2'd1, 3'd1, 16'sd5, 1'b1);

        // Random phases over several channel counts and settings. The second
        // runs with no idle cycles on either side; the third stops in the
        // middle until every owed channel has been transferred.
        for (int p = 0; p < 6; p++)
        begin
            configure({20'($urandom), ACTIVE_W'(phase_active[p])}, random_setting(),
                      random_setting(), random_setting(), random_setting(), p == 3);
            steady = (p == 1);
            for (int i = 0; i < 75; i++)
            begin
                if (p == 2 && i == 40)
                    drain();
                send_random();
            end
            steady = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (sb.expected_mix.size() != 0)
            sb.report($sformatf("channel %0d never arrived",
                                sb.expected_mix.pop_front().channel));

        $display("run covered %0d samples and %0d frame ends under %0d register settings,",
                 sb.samples, sb.frames, sb.settings_used);
        $display("with %0d mixed channels transferred and checked", sb.mixes);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
